// ----- sv/rsp_pkg.sv -----
// Shared widths, constants and register indexes of the radial sine pattern generator.
package rsp_pkg;

  localparam int unsigned COORD_W     = 12;
  localparam int unsigned DIM_W       = 13;
  localparam int unsigned FREQ_W      = 16;
  localparam int unsigned INTENS_W    = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // Radicand is (x*x + y*y) << 16, padded to an even width for the root.
  localparam int unsigned SUM_W       = 2 * COORD_W + 1;
  localparam int unsigned RAD_IN_W    = SUM_W + 17;
  localparam int unsigned ROOT_W      = RAD_IN_W / 2;
  localparam int unsigned PROD_W      = FREQ_W + ROOT_W;

  localparam int unsigned MAX_DIM_DEF    = 4096;
  localparam int unsigned PHASE_BITS_DEF = 16;

  localparam int unsigned Q_W         = 31;
  localparam logic [Q_W-1:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [Q_W-1:0] C1_Q30   = 31'd1686629713;
  localparam logic [Q_W-1:0] C3_Q30   = 31'd693598672;
  localparam logic [Q_W-1:0] C5_Q30   = 31'd85569278;
  localparam logic [Q_W-1:0] C7_Q30   = 31'd5026990;
  localparam logic [Q_W-1:0] C9_Q30   = 31'd172273;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_FREQUENCY = 2'd2;

  localparam logic [DIM_W-1:0]  FRAME_DIM_RST = 13'd512;
  localparam logic [FREQ_W-1:0] FREQ_RST      = 16'd256;

endpackage

// ----- sv/rsp_sqrt.sv -----
// Pipelined restoring integer square root, one result bit per stage.
module rsp_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic [rsp_pkg::RAD_IN_W-1:0] in_val,
  output logic                        out_vld,
  output logic [rsp_pkg::ROOT_W-1:0]  out_root
);
  import rsp_pkg::*;

  localparam int unsigned RW = ROOT_W;
  localparam int unsigned VW = RAD_IN_W;

  logic [RW+1:0] rem_r  [1:RW];
  logic [RW-1:0] root_r [1:RW];
  logic [VW-1:0] val_r  [1:RW];
  logic          vld_r  [1:RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [RW+1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [VW-1:0] val_in;
    logic          vld_in;
    logic [RW+1:0] rin;
    logic [RW+1:0] trial;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = in_val;
      assign vld_in  = in_vld;
    end else begin : g_next
      assign rem_in  = rem_r[i];
      assign root_in = root_r[i];
      assign val_in  = val_r[i];
      assign vld_in  = vld_r[i];
    end

    assign rin   = {rem_in[RW-1:0], val_in[VW-1-2*i -: 2]};
    assign trial = {root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      val_r[i+1] <= val_in;
      if (rin >= trial) begin
        rem_r[i+1]  <= rin - trial;
        root_r[i+1] <= {root_in[RW-2:0], 1'b1};
      end else begin
        rem_r[i+1]  <= rin;
        root_r[i+1] <= {root_in[RW-2:0], 1'b0};
      end
    end
  end

  assign out_vld  = vld_r[RW];
  assign out_root = root_r[RW];

endmodule

// ----- sv/rsp_div.sv -----
// Pipelined restoring divider by the radius normaliser, one quotient bit per stage.
module rsp_div #(
  parameter int unsigned MAX_DIM    = rsp_pkg::MAX_DIM_DEF,
  parameter int unsigned PHASE_BITS = rsp_pkg::PHASE_BITS_DEF,
  localparam int unsigned NW        = $clog2(MAX_DIM + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  logic [rsp_pkg::PROD_W-1:0] in_prod,
  input  logic [NW-1:0]             norm,
  output logic                      out_vld,
  output logic [PHASE_BITS-1:0]     out_phase
);
  import rsp_pkg::*;

  localparam int unsigned DW = PROD_W + PHASE_BITS - 16;

  logic [DW-1:0] dvd;

  // Phase = floor(prod * 2^PHASE_BITS / 2^16 / n), kept modulo one turn.
  if (PHASE_BITS >= 16) begin : g_up
    assign dvd = DW'(in_prod) << (PHASE_BITS - 16);
  end else begin : g_down
    assign dvd = in_prod[PROD_W-1 -: DW];
  end

  logic [NW-1:0]         rem_r [1:DW];
  logic [PHASE_BITS-1:0] q_r   [1:DW];
  logic [DW-1:0]         d_r   [1:DW];
  logic                  vld_r [1:DW];

  for (genvar i = 0; i < DW; i++) begin : g_stage
    logic [NW-1:0]         rem_in;
    logic [PHASE_BITS-1:0] q_in;
    logic [DW-1:0]         d_in;
    logic                  vld_in;
    logic [NW:0]           rin;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign q_in   = '0;
      assign d_in   = dvd;
      assign vld_in = in_vld;
    end else begin : g_next
      assign rem_in = rem_r[i];
      assign q_in   = q_r[i];
      assign d_in   = d_r[i];
      assign vld_in = vld_r[i];
    end

    assign rin = {rem_in, d_in[DW-1-i]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      d_r[i+1] <= d_in;
      if (rin >= {1'b0, norm}) begin
        rem_r[i+1] <= NW'(rin - {1'b0, norm});
        q_r[i+1]   <= {q_in[PHASE_BITS-2:0], 1'b1};
      end else begin
        rem_r[i+1] <= rin[NW-1:0];
        q_r[i+1]   <= {q_in[PHASE_BITS-2:0], 1'b0};
      end
    end
  end

  assign out_vld   = vld_r[DW];
  assign out_phase = q_r[DW];

endmodule

// ----- sv/rsp_sine.sv -----
// Pipelined quarter-wave polynomial sine and gray level mapping.
module rsp_sine #(
  parameter int unsigned PHASE_BITS = rsp_pkg::PHASE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [PHASE_BITS-1:0]         in_phase,
  output logic                          out_vld,
  output logic [rsp_pkg::INTENS_W-1:0]  out_intensity
);
  import rsp_pkg::*;

  localparam int unsigned NS = 7;

  logic           vld_r  [1:NS];
  logic [1:0]     quad_r [1:NS];
  logic [Q_W-1:0] t_r    [1:NS];
  logic [Q_W-1:0] t2_r   [2:5];
  logic [Q_W-1:0] acc_r  [3:6];
  logic [Q_W-1:0] s_r;
  logic [Q_W-1:0] t_raw;
  logic [2*Q_W-1:0] p_t2, p_a3, p_a4, p_a5, p_a6, p_s;
  logic [Q_W+6:0] m;
  logic [7:0]     mag_floor;
  logic [7:0]     mag_ceil;
  logic [INTENS_W-1:0] intens_nxt;
  logic [INTENS_W-1:0] intens_r;
  logic                out_vld_r;

  assign t_raw = Q_W'(in_phase[PHASE_BITS-3:0]) << (32 - PHASE_BITS);

  for (genvar k = 1; k <= NS; k++) begin : g_vld
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= (k == 1) ? in_vld : vld_r[(k == 1) ? 1 : k - 1];
      end
    end
    if (k > 1) begin : g_carry
      always_ff @(posedge clk) begin
        quad_r[k] <= quad_r[k-1];
        t_r[k]    <= t_r[k-1];
      end
    end
  end

  assign p_t2 = t_r[1] * t_r[1];
  assign p_a3 = t2_r[2] * C9_Q30;
  assign p_a4 = t2_r[3] * acc_r[3];
  assign p_a5 = t2_r[4] * acc_r[4];
  assign p_a6 = t2_r[5] * acc_r[5];
  assign p_s  = t_r[6] * acc_r[6];

  always_ff @(posedge clk) begin
    // Odd quadrants run the quarter wave backwards.
    quad_r[1] <= in_phase[PHASE_BITS-1 -: 2];
    t_r[1]    <= in_phase[PHASE_BITS-2] ? ONE_Q30 - t_raw : t_raw;
    t2_r[2]   <= p_t2[Q_W+29:30];
    t2_r[3]   <= t2_r[2];
    t2_r[4]   <= t2_r[3];
    t2_r[5]   <= t2_r[4];
    acc_r[3]  <= C7_Q30 - p_a3[Q_W+29:30];
    acc_r[4]  <= C5_Q30 - p_a4[Q_W+29:30];
    acc_r[5]  <= C3_Q30 - p_a5[Q_W+29:30];
    acc_r[6]  <= C1_Q30 - p_a6[Q_W+29:30];
    s_r       <= (p_s[2*Q_W-1:30] > {2'b00, ONE_Q30}) ? ONE_Q30 : p_s[Q_W+29:30];
  end

  // 127 * s by shift and subtract; the magnitude is at most 127.
  always_comb begin
    m          = {s_r, 7'd0} - {7'd0, s_r};
    mag_floor  = {1'b0, m[36:30]};
    mag_ceil   = (m[29:0] != '0) ? mag_floor + 8'd1 : mag_floor;
    if (!quad_r[NS][1]) begin
      intens_nxt = 8'd128 + mag_floor;
    end else begin
      intens_nxt = 8'd128 - mag_ceil;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    intens_r <= intens_nxt;
  end

  assign out_vld       = out_vld_r;
  assign out_intensity = intens_r;

endmodule

// ----- sv/radial_sine_pattern_generator.sv -----
// Top level of the radial sine ring test pattern generator.
//
//   channel  ports                                   transaction
//   input    start, busy, in_pixel_x, in_pixel_y     start high while busy is low
//   result   out_valid, out_intensity                out_valid high for one cycle
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid and cfg_ready high
//
// One pixel is accepted every clock; busy is always low. The pipeline holds three input
// and squaring stages, 21 square root stages, one multiply, PHASE_BITS + 21 divider
// stages and eight sine stages.
// Synchronous reset empties the pipeline and restores the register defaults.
// The receiver cannot stall, so results leave the pipeline in the cycle they finish.
module radial_sine_pattern_generator #(
  parameter int unsigned MAX_DIM    = rsp_pkg::MAX_DIM_DEF,
  parameter int unsigned PHASE_BITS = rsp_pkg::PHASE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [rsp_pkg::COORD_W-1:0]     in_pixel_x,
  input  logic [rsp_pkg::COORD_W-1:0]     in_pixel_y,
  output logic                            out_valid,
  output logic [rsp_pkg::INTENS_W-1:0]    out_intensity,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rsp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rsp_pkg::*;

  localparam int unsigned NW = $clog2(MAX_DIM + 1);

  logic [DIM_W-1:0]  frame_width_r;
  logic [DIM_W-1:0]  frame_height_r;
  logic [FREQ_W-1:0] ring_frequency_r;
  logic [DIM_W-1:0]  dim_min;
  logic [NW-1:0]     norm;

  logic [COORD_W-1:0]   x_r, y_r;
  logic [2*COORD_W-1:0] xx_r, yy_r;
  logic [SUM_W-1:0]     sum_r;
  logic                 v1_r, v2_r, v3_r;
  logic                 root_vld;
  logic [ROOT_W-1:0]    root;
  logic [PROD_W-1:0]    prod_r;
  logic                 prod_vld_r;
  logic                 phase_vld;
  logic [PHASE_BITS-1:0] phase;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r    <= FRAME_DIM_RST;
      frame_height_r   <= FRAME_DIM_RST;
      ring_frequency_r <= FREQ_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:    frame_width_r    <= cfg_data[DIM_W-1:0];
        CFG_FRAME_HEIGHT:   frame_height_r   <= cfg_data[DIM_W-1:0];
        CFG_RING_FREQUENCY: ring_frequency_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A zero normaliser counts as one, and anything above MAX_DIM saturates.
  always_comb begin
    dim_min = (frame_width_r < frame_height_r) ? frame_width_r : frame_height_r;
    if (dim_min == '0) begin
      norm = NW'(1);
    end else if (32'(dim_min) > MAX_DIM) begin
      norm = NW'(MAX_DIM);
    end else begin
      norm = NW'(dim_min);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      v1_r       <= start;
      v2_r       <= v1_r;
      v3_r       <= v2_r;
      prod_vld_r <= root_vld;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= in_pixel_x;
    y_r    <= in_pixel_y;
    xx_r   <= x_r * x_r;
    yy_r   <= y_r * y_r;
    sum_r  <= {1'b0, xx_r} + {1'b0, yy_r};
    prod_r <= ring_frequency_r * root;
  end

  rsp_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v3_r),
    .in_val   ({1'b0, sum_r, 16'd0}),
    .out_vld  (root_vld),
    .out_root (root)
  );

  rsp_div #(
    .MAX_DIM    (MAX_DIM),
    .PHASE_BITS (PHASE_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (prod_vld_r),
    .in_prod   (prod_r),
    .norm      (norm),
    .out_vld   (phase_vld),
    .out_phase (phase)
  );

  rsp_sine #(
    .PHASE_BITS (PHASE_BITS)
  ) u_sine (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_vld        (phase_vld),
    .in_phase      (phase),
    .out_vld       (out_valid),
    .out_intensity (out_intensity)
  );

endmodule
